@@ rtl/vss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vss_pkg
// Shared types and constants of the speech segment smoother: register map,
// register layout, reset values, field widths and queue depth.
// ----------------------------------------------------------------------------
package vss_pkg;

    localparam int unsigned MERGE_W     = 10;
    localparam int unsigned MIN_W       = 12;
    localparam int unsigned SHIFT_W     = 7;
    localparam int unsigned FLEN_W      = 8;
    localparam int unsigned FRAME_OUT_W = 24;
    localparam int unsigned MS_W        = 32;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 4;
    localparam int unsigned Q_DEPTH     = 4;

    localparam logic [MERGE_W-1:0] MERGE_RST = MERGE_W'(50);
    localparam logic [MIN_W-1:0]   MIN_RST   = MIN_W'(200);
    localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(10);
    localparam logic [FLEN_W-1:0]  FLEN_RST  = FLEN_W'(25);

    typedef enum logic [1:0] {
        CFG_MERGE_GAP  = 2'd0,
        CFG_MIN_SPEECH = 2'd1,
        CFG_SHIFT_MS   = 2'd2,
        CFG_FLEN_MS    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [MERGE_W-1:0] merge_gap_frames;
        logic [MIN_W-1:0]   min_speech_frames;
        logic [SHIFT_W-1:0] frame_shift_ms;
        logic [FLEN_W-1:0]  frame_len_ms;
    } t_cfg;

endpackage
`default_nettype wire

@@ rtl/vad_segment_smoother.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vad_segment_smoother
// Groups per-frame speech flags into intervals, merges close ones and
// reports the long ones with frame and millisecond stamps.
// Throughput: one frame word per cycle while the queue has room; a frame
// that closes two intervals fills two queue slots, the back drains one
// interval word per cycle unless the receiver stalls. An interval passes
// the queue and then the output register. The input stalls while fewer
// than two queue slots are free. Reset (synchronous, active low) clears the
// stream state, queue pointers and output valid, loads register defaults.
// ----------------------------------------------------------------------------
module vad_segment_smoother #(
    parameter int unsigned FRAME_INDEX_BITS = 24
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [vss_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire  [vss_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [vss_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire                                  i_speech_flag,
    input  wire                                  i_end_of_stream,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [vss_pkg::FRAME_OUT_W-1:0]      o_start_frame,
    output logic [vss_pkg::FRAME_OUT_W-1:0]      o_end_frame,
    output logic [vss_pkg::MS_W-1:0]             o_start_ms,
    output logic [vss_pkg::MS_W-1:0]             o_end_ms,
    output logic                                 o_last_result
);

    localparam int unsigned EW = 2 * FRAME_INDEX_BITS + 1;
    localparam int unsigned DW = vss_pkg::APB_DATA_W;

    vss_pkg::t_cfg     r_cfg;
    vss_pkg::t_cfg_idx reg_idx;
    logic              wr_en;
    logic              q_full, q_valid, q_pop;
    logic [1:0]        push_n;
    logic [EW-1:0]     entry0, entry1, q_data;

    assign reg_idx = vss_pkg::t_cfg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.merge_gap_frames  <= vss_pkg::MERGE_RST;
            r_cfg.min_speech_frames <= vss_pkg::MIN_RST;
            r_cfg.frame_shift_ms    <= vss_pkg::SHIFT_RST;
            r_cfg.frame_len_ms      <= vss_pkg::FLEN_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                vss_pkg::CFG_MERGE_GAP: begin
                    r_cfg.merge_gap_frames <= pwdata[vss_pkg::MERGE_W-1:0];
                end
                vss_pkg::CFG_MIN_SPEECH: begin
                    r_cfg.min_speech_frames <= pwdata[vss_pkg::MIN_W-1:0];
                end
                vss_pkg::CFG_SHIFT_MS: begin
                    r_cfg.frame_shift_ms <= pwdata[vss_pkg::SHIFT_W-1:0];
                end
                vss_pkg::CFG_FLEN_MS: begin
                    r_cfg.frame_len_ms <= pwdata[vss_pkg::FLEN_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            vss_pkg::CFG_MERGE_GAP:  prdata = DW'(r_cfg.merge_gap_frames);
            vss_pkg::CFG_MIN_SPEECH: prdata = DW'(r_cfg.min_speech_frames);
            vss_pkg::CFG_SHIFT_MS:   prdata = DW'(r_cfg.frame_shift_ms);
            vss_pkg::CFG_FLEN_MS:    prdata = DW'(r_cfg.frame_len_ms);
        endcase
    end

    assign o_in_stall = q_full;

    vss_front #(
        .FIB (FRAME_INDEX_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .i_q_full        (q_full),
        .i_speech_flag   (i_speech_flag),
        .i_end_of_stream (i_end_of_stream),
        .o_push_n        (push_n),
        .o_entry0        (entry0),
        .o_entry1        (entry1)
    );

    vss_queue #(
        .EW (EW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_wdata0 (entry0),
        .i_wdata1 (entry1),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_rdata  (q_data)
    );

    vss_back #(
        .FIB (FRAME_INDEX_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_start_frame (o_start_frame),
        .o_end_frame   (o_end_frame),
        .o_start_ms    (o_start_ms),
        .o_end_ms      (o_end_ms),
        .o_last_result (o_last_result)
    );

endmodule
`default_nettype wire

@@ rtl/vss_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vss_front
// Takes one frame word per cycle while the queue has room, tracks runs and
// the held interval, and hands up to two finished intervals to the queue.
// ----------------------------------------------------------------------------
module vss_front #(
    parameter int unsigned FIB = 24
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire vss_pkg::t_cfg    i_cfg,
    input  wire                   i_in_valid,
    input  wire                   i_q_full,
    input  wire                   i_speech_flag,
    input  wire                   i_end_of_stream,
    output logic [1:0]            o_push_n,
    output logic [2*FIB:0]        o_entry0,
    output logic [2*FIB:0]        o_entry1
);

    localparam int unsigned LW = (FIB + 1 > vss_pkg::MIN_W) ? FIB + 1 : vss_pkg::MIN_W;
    localparam int unsigned GW = (FIB > vss_pkg::MERGE_W) ? FIB : vss_pkg::MERGE_W;

    typedef struct packed {
        logic [FIB-1:0] seg_start;
        logic [FIB-1:0] seg_end;
        logic           last_result;
    } t_entry;

    logic [FIB-1:0] r_frame, n_frame;
    logic           r_in_run, n_in_run;
    logic [FIB-1:0] r_run_start, n_run_start;
    logic           r_have, n_have;
    logic [FIB-1:0] r_pend_start, n_pend_start;
    logic [FIB-1:0] r_pend_end, n_pend_end;

    logic           accept;
    logic           fin;
    logic [FIB-1:0] fs, fe, gap, bs, be;
    logic           merge, a_ok, b_ok;
    t_entry         ent0, ent1;

    function automatic logic is_long(input logic [FIB-1:0] s, input logic [FIB-1:0] e,
                                     input logic [vss_pkg::MIN_W-1:0] min_len);
        logic [LW-1:0] len;
        len = LW'(e) - LW'(s) + LW'(1);
        return len >= LW'(min_len);
    endfunction

    assign accept = i_in_valid && !i_q_full;

    always_comb begin
        n_frame      = r_frame;
        n_in_run     = r_in_run;
        n_run_start  = r_run_start;
        n_have       = r_have;
        n_pend_start = r_pend_start;
        n_pend_end   = r_pend_end;
        fin          = 1'b0;
        fs           = r_frame;
        fe           = r_frame;
        a_ok         = 1'b0;
        b_ok         = 1'b0;
        bs           = r_pend_start;
        be           = r_pend_end;

        if (i_speech_flag) begin
            if (!r_in_run) begin
                n_in_run    = 1'b1;
                n_run_start = r_frame;
            end
            if (i_end_of_stream) begin
                fin = 1'b1;
                fs  = r_in_run ? r_run_start : r_frame;
                fe  = r_frame;
            end
        end else if (r_in_run) begin
            fin = 1'b1;
            fs  = r_run_start;
            fe  = (r_frame > r_run_start) ? r_frame - FIB'(1) : r_run_start;
        end

        gap   = (fs >= r_pend_end) ? fs - r_pend_end : '0;
        merge = r_have && (GW'(gap) <= GW'(i_cfg.merge_gap_frames));

        if (fin) begin
            n_in_run = 1'b0;
            if (merge) begin
                n_pend_end = fe;
            end else begin
                a_ok         = r_have && is_long(r_pend_start, r_pend_end,
                                                 i_cfg.min_speech_frames);
                n_pend_start = fs;
                n_pend_end   = fe;
                n_have       = 1'b1;
            end
        end

        if (i_end_of_stream) begin
            bs           = n_pend_start;
            be           = n_pend_end;
            b_ok         = n_have && is_long(n_pend_start, n_pend_end,
                                             i_cfg.min_speech_frames);
            n_frame      = '0;
            n_in_run     = 1'b0;
            n_run_start  = '0;
            n_have       = 1'b0;
            n_pend_start = '0;
            n_pend_end   = '0;
        end else if (r_frame != {FIB{1'b1}}) begin
            n_frame = r_frame + FIB'(1);
        end
    end

    always_comb begin
        ent1.seg_start   = bs;
        ent1.seg_end     = be;
        ent1.last_result = 1'b1;
        if (a_ok) begin
            ent0.seg_start   = r_pend_start;
            ent0.seg_end     = r_pend_end;
            ent0.last_result = !b_ok;
        end else begin
            ent0 = ent1;
        end
        if (!accept) begin
            o_push_n = 2'd0;
        end else begin
            o_push_n = 2'(a_ok) + 2'(b_ok);
        end
    end

    assign o_entry0 = ent0;
    assign o_entry1 = ent1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame      <= '0;
            r_in_run     <= 1'b0;
            r_run_start  <= '0;
            r_have       <= 1'b0;
            r_pend_start <= '0;
            r_pend_end   <= '0;
        end else if (accept) begin
            r_frame      <= n_frame;
            r_in_run     <= n_in_run;
            r_run_start  <= n_run_start;
            r_have       <= n_have;
            r_pend_start <= n_pend_start;
            r_pend_end   <= n_pend_end;
        end
    end

endmodule
`default_nettype wire

@@ rtl/vss_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vss_queue
// Short interval queue between front and back; takes up to two words per
// cycle and gives up to one.
// ----------------------------------------------------------------------------
module vss_queue #(
    parameter int unsigned EW = 49
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire  [1:0]    i_push_n,
    input  wire  [EW-1:0] i_wdata0,
    input  wire  [EW-1:0] i_wdata1,
    input  wire           i_pop,
    output logic          o_full,
    output logic          o_valid,
    output logic [EW-1:0] o_rdata
);

    localparam int unsigned DEPTH = vss_pkg::Q_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = PW + 1;

    logic [EW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_count, n_count;
    logic          pop;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rp];
    // room for two words is needed before the front takes another frame
    assign o_full  = (r_count > CW'(DEPTH - 2));

    always_comb begin
        n_wp    = r_wp + PW'(i_push_n);
        n_rp    = r_rp + PW'(pop);
        n_count = r_count + CW'(i_push_n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_wdata0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wp + PW'(1)] <= i_wdata1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ rtl/vss_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vss_back
// Converts queued intervals to frame and millisecond stamps and holds them
// in the output register.
// ----------------------------------------------------------------------------
module vss_back #(
    parameter int unsigned FIB = 24
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire vss_pkg::t_cfg                   i_cfg,
    input  wire                                  i_q_valid,
    input  wire  [2*FIB:0]                       i_q_data,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [vss_pkg::FRAME_OUT_W-1:0]      o_start_frame,
    output logic [vss_pkg::FRAME_OUT_W-1:0]      o_end_frame,
    output logic [vss_pkg::MS_W-1:0]             o_start_ms,
    output logic [vss_pkg::MS_W-1:0]             o_end_ms,
    output logic                                 o_last_result
);

    localparam int unsigned MS_W = vss_pkg::MS_W;
    localparam int unsigned PW   = MS_W + vss_pkg::SHIFT_W;

    typedef struct packed {
        logic [FIB-1:0] seg_start;
        logic [FIB-1:0] seg_end;
        logic           last_result;
    } t_entry;

    t_entry            ent;
    logic              load;
    logic [PW-1:0]     start_prod, end_prod;
    logic              r_valid;
    logic [vss_pkg::FRAME_OUT_W-1:0] r_start_frame, r_end_frame;
    logic [MS_W-1:0]   r_start_ms, r_end_ms;
    logic              r_last;

    assign ent   = i_q_data;
    assign load  = i_q_valid && (!r_valid || !i_out_stall);
    assign o_pop = load;

    assign start_prod = PW'(MS_W'(ent.seg_start)) * PW'(i_cfg.frame_shift_ms);
    assign end_prod   = PW'(MS_W'(ent.seg_end)) * PW'(i_cfg.frame_shift_ms)
                        + PW'(i_cfg.frame_len_ms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_start_frame <= vss_pkg::FRAME_OUT_W'(ent.seg_start);
            r_end_frame   <= vss_pkg::FRAME_OUT_W'(ent.seg_end);
            r_start_ms    <= start_prod[MS_W-1:0];
            r_end_ms      <= end_prod[MS_W-1:0];
            r_last        <= ent.last_result;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_start_frame = r_start_frame;
    assign o_end_frame   = r_end_frame;
    assign o_start_ms    = r_start_ms;
    assign o_end_ms      = r_end_ms;
    assign o_last_result = r_last;

endmodule
`default_nettype wire

@@ verif/vad_segment_smoother_tb.sv @@
// ----------------------------------------------------------------------------
// vad_segment_smoother_tb
// Self-checking bench for the speech segment smoother. A short table of
// frame words and register writes comes first: empty stream, single-frame
// runs, the merge limit, zero and full-scale registers, and a frame that
// closes two intervals. Random streams follow under several register
// settings. Most of them are well-formed runs and gaps placed near the
// merge and length limits, and the rest are noise. Both sides idle in
// random bursts. The receiver holds off once for a long stretch, and the
// sender pauses once until the bench has drained. Every interval word is
// compared field by field against typed table words or the in-bench model.
// ----------------------------------------------------------------------------
module vad_segment_smoother_tb;

    typedef struct packed {
        logic [vss_pkg::FRAME_OUT_W-1:0] seg_start;
        logic [vss_pkg::FRAME_OUT_W-1:0] seg_end;
        logic [vss_pkg::MS_W-1:0]        start_ms;
        logic [vss_pkg::MS_W-1:0]        end_ms;
        logic                            last_result;
    } t_interval;

    typedef enum {ROW_FRAME, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        vss_pkg::t_cfg_idx reg_idx;
        logic [31:0]       value;
        bit                speech;
        bit                eos;
        int                n_typed;
        t_interval         typed [2];
    } t_stim_row;

    localparam int N_PHASES     = 7;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [vss_pkg::APB_ADDR_W-1:0]  paddr;
    logic [vss_pkg::APB_DATA_W-1:0]  pwdata;
    logic [vss_pkg::APB_DATA_W-1:0]  prdata;
    logic                            pready;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_speech_flag;
    logic                            i_end_of_stream;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [vss_pkg::FRAME_OUT_W-1:0] o_start_frame;
    logic [vss_pkg::FRAME_OUT_W-1:0] o_end_frame;
    logic [vss_pkg::MS_W-1:0]        o_start_ms;
    logic [vss_pkg::MS_W-1:0]        o_end_ms;
    logic                            o_last_result;

    // smoother model: registers and stream state
    logic [vss_pkg::MERGE_W-1:0]     cfg_merge = vss_pkg::MERGE_RST;
    logic [vss_pkg::MIN_W-1:0]       cfg_min   = vss_pkg::MIN_RST;
    logic [vss_pkg::SHIFT_W-1:0]     cfg_shift = vss_pkg::SHIFT_RST;
    logic [vss_pkg::FLEN_W-1:0]      cfg_flen  = vss_pkg::FLEN_RST;
    logic [vss_pkg::FRAME_OUT_W-1:0] frame_idx = '0;
    logic [vss_pkg::FRAME_OUT_W-1:0] run_start = '0;
    logic [vss_pkg::FRAME_OUT_W-1:0] held_start = '0;
    logic [vss_pkg::FRAME_OUT_W-1:0] held_end = '0;
    bit                              in_run = 1'b0;
    bit                              have_held = 1'b0;

    t_interval   interval_q [$];
    t_interval   frame_res [$];
    t_stim_row   steps [$];
    int unsigned mismatch_count = 0;
    int unsigned frames_sent = 0;

    bit          calm = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b1;
    int unsigned tx_mode_left = 0;
    int unsigned rx_mode_left = 0;
    int unsigned stall_left = 0;

    int unsigned phase_cfg [N_PHASES][4] = '{
        '{3, 4, 10, 25}, '{0, 1, 1, 1}, '{8, 12, 100, 200}, '{40, 60, 127, 255},
        '{1, 0, 0, 0}, '{50, 200, 10, 25}, '{5, 6, 33, 77}
    };
    int unsigned phase_budget [N_PHASES] = '{150, 150, 150, 100, 120, 250, 150};

    vad_segment_smoother uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_speech_flag   (i_speech_flag),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_start_frame   (o_start_frame),
        .o_end_frame     (o_end_frame),
        .o_start_ms      (o_start_ms),
        .o_end_ms        (o_end_ms),
        .o_last_result   (o_last_result)
    );

    function automatic void queue_word(input t_interval r);
        interval_q.insert(interval_q.size(), r);
    endfunction

    function automatic void add_row(input t_stim_row row);
        steps.insert(steps.size(), row);
    endfunction

    function automatic void report_if_long(input logic [vss_pkg::FRAME_OUT_W-1:0] s,
                                           input logic [vss_pkg::FRAME_OUT_W-1:0] e);
        logic [63:0] len;
        t_interval   r;
        len = 64'(e) - 64'(s) + 64'd1;
        if (len >= 64'(cfg_min)) begin
            r.seg_start   = s;
            r.seg_end     = e;
            r.start_ms    = vss_pkg::MS_W'(64'(s) * 64'(cfg_shift));
            r.end_ms      = vss_pkg::MS_W'(64'(e) * 64'(cfg_shift) + 64'(cfg_flen));
            r.last_result = 1'b0;
            frame_res.insert(frame_res.size(), r);
        end
    endfunction

    function automatic void close_run(input logic [vss_pkg::FRAME_OUT_W-1:0] s,
                                      input logic [vss_pkg::FRAME_OUT_W-1:0] e);
        logic [vss_pkg::FRAME_OUT_W-1:0] gap;
        gap = (s >= held_end) ? s - held_end : '0;
        if (have_held && gap <= vss_pkg::FRAME_OUT_W'(cfg_merge)) begin
            held_end = e;
        end else begin
            if (have_held) report_if_long(held_start, held_end);
            held_start = s;
            held_end   = e;
            have_held  = 1'b1;
        end
        in_run = 1'b0;
    endfunction

    function automatic void smooth_frame(input bit speech, input bit eos);
        frame_res.delete();
        if (speech) begin
            if (!in_run) begin
                in_run    = 1'b1;
                run_start = frame_idx;
            end
            if (eos) close_run(run_start, frame_idx);
        end else if (in_run) begin
            close_run(run_start, (frame_idx > run_start) ?
                      frame_idx - vss_pkg::FRAME_OUT_W'(1) : run_start);
        end
        if (eos) begin
            if (have_held) report_if_long(held_start, held_end);
            frame_idx  = '0;
            in_run     = 1'b0;
            run_start  = '0;
            have_held  = 1'b0;
            held_start = '0;
            held_end   = '0;
        end else if (frame_idx != '1) begin
            frame_idx = frame_idx + vss_pkg::FRAME_OUT_W'(1);
        end
        if (frame_res.size() != 0) begin
            frame_res[frame_res.size() - 1].last_result = 1'b1;
        end
    endfunction

    function automatic t_stim_row frame_row(input bit speech, input bit eos,
                                            input int n_typed = -1,
                                            input t_interval r0 = '0,
                                            input t_interval r1 = '0);
        t_stim_row row;
        row.kind     = ROW_FRAME;
        row.reg_idx  = vss_pkg::CFG_MERGE_GAP;
        row.value    = '0;
        row.speech   = speech;
        row.eos      = eos;
        row.n_typed  = n_typed;
        row.typed[0] = r0;
        row.typed[1] = r1;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input vss_pkg::t_cfg_idx idx,
                                          input logic [31:0] value);
        t_stim_row row;
        row         = frame_row(1'b0, 1'b0);
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.value   = value;
        return row;
    endfunction

    // lengths just below, at and above a limit, or anywhere up to a little past it
    function automatic int unsigned near_len(input int unsigned limit);
        case ($urandom_range(0, 3))
            0: return (limit > 1) ? limit - 1 : 1;
            1: return (limit == 0) ? 1 : limit;
            2: return limit + 1;
            default: return $urandom_range(1, limit + 3);
        endcase
    endfunction

    task automatic send_frame(input bit speech, input bit eos, input bit typed);
        int unsigned gap;
        if (tx_mode_left == 0) begin
            tx_idle      = !tx_idle;
            tx_mode_left = $urandom_range(20, 120);
        end
        tx_mode_left--;
        if (!calm && tx_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_speech_flag   <= speech;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (o_in_stall);
        frames_sent++;
        smooth_frame(speech, eos);
        if (!typed) foreach (frame_res[j]) queue_word(frame_res[j]);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (interval_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input vss_pkg::t_cfg_idx idx, input logic [31:0] value);
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= vss_pkg::APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value) begin
            $error("%s readback: expected %0d, got %0d", idx.name(), value, prdata);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            vss_pkg::CFG_MERGE_GAP:  cfg_merge = value[vss_pkg::MERGE_W-1:0];
            vss_pkg::CFG_MIN_SPEECH: cfg_min   = value[vss_pkg::MIN_W-1:0];
            vss_pkg::CFG_SHIFT_MS:   cfg_shift = value[vss_pkg::SHIFT_W-1:0];
            vss_pkg::CFG_FLEN_MS:    cfg_flen  = value[vss_pkg::FLEN_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("vad_segment_smoother_tb: FAIL");
        $finish;
    end

    // receiver side: stall bursts, stretches without them, one long hold
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
                long_hold_req = 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_idle      = !rx_idle;
                    rx_mode_left = $urandom_range(50, 300);
                end
                rx_mode_left--;
                if (stall_left == 0 && !calm && rx_idle && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 17);
                if (stall_left != 0) begin
                    i_out_stall <= 1'b1;
                    stall_left--;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // interval word check
    initial begin
        t_interval exp;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (interval_q.size() == 0) begin
                    $error("interval word with none expected: o_start_frame %0d o_end_frame %0d",
                           o_start_frame, o_end_frame);
                    mismatch_count++;
                end else begin
                    exp = interval_q.pop_front();
                    if (o_start_frame !== exp.seg_start) begin
                        $error("o_start_frame: expected %0d, got %0d",
                               exp.seg_start, o_start_frame);
                        mismatch_count++;
                    end
                    if (o_end_frame !== exp.seg_end) begin
                        $error("o_end_frame: expected %0d, got %0d", exp.seg_end, o_end_frame);
                        mismatch_count++;
                    end
                    if (o_start_ms !== exp.start_ms) begin
                        $error("start_ms: expected %0d, got %0d", exp.start_ms, o_start_ms);
                        mismatch_count++;
                    end
                    if (o_end_ms !== exp.end_ms) begin
                        $error("end_ms: expected %0d, got %0d", exp.end_ms, o_end_ms);
                        mismatch_count++;
                    end
                    if (o_last_result !== exp.last_result) begin
                        $error("last_result: expected %0d, got %0d",
                               exp.last_result, o_last_result);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        t_stim_row   row;
        int unsigned budget;
        int unsigned len;
        int unsigned nruns;
        int unsigned ending;
        bit          paused;

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_in_valid      = 1'b0;
        i_speech_flag   = 1'b0;
        i_end_of_stream = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: empty stream, then a one-frame run that is too short
        add_row(frame_row(1'b0, 1'b1, 0));
        add_row(frame_row(1'b1, 1'b1, 0));
        add_row(frame_row(1'b1, 1'b0));
        add_row(frame_row(1'b0, 1'b1));
        add_row(reg_row(vss_pkg::CFG_MIN_SPEECH, 1));
        add_row(reg_row(vss_pkg::CFG_SHIFT_MS, 100));
        add_row(reg_row(vss_pkg::CFG_FLEN_MS, 200));
        add_row(frame_row(1'b1, 1'b1, 1,
                          t_interval'{24'd0, 24'd0, 32'd0, 32'd200, 1'b1}));
        // no merging: the final speech frame closes two intervals
        add_row(reg_row(vss_pkg::CFG_MERGE_GAP, 0));
        add_row(frame_row(1'b1, 1'b0));
        add_row(frame_row(1'b0, 1'b0, 0));
        add_row(frame_row(1'b1, 1'b0));
        add_row(frame_row(1'b0, 1'b0, 1,
                          t_interval'{24'd0, 24'd0, 32'd0, 32'd200, 1'b1}));
        add_row(frame_row(1'b1, 1'b1, 2,
                          t_interval'{24'd2, 24'd2, 32'd200, 32'd400, 1'b0},
                          t_interval'{24'd4, 24'd4, 32'd400, 32'd600, 1'b1}));
        // zero registers
        add_row(reg_row(vss_pkg::CFG_MIN_SPEECH, 0));
        add_row(reg_row(vss_pkg::CFG_SHIFT_MS, 0));
        add_row(reg_row(vss_pkg::CFG_FLEN_MS, 0));
        add_row(frame_row(1'b0, 1'b1, 0));
        add_row(frame_row(1'b1, 1'b0));
        add_row(frame_row(1'b0, 1'b1, 1,
                          t_interval'{24'd0, 24'd0, 32'd0, 32'd0, 1'b1}));
        // gap right at the merge limit, then two past it
        add_row(reg_row(vss_pkg::CFG_MERGE_GAP, 2));
        add_row(frame_row(1'b1, 1'b0));
        add_row(frame_row(1'b0, 1'b0));
        add_row(frame_row(1'b1, 1'b0));
        add_row(frame_row(1'b0, 1'b0));
        add_row(frame_row(1'b0, 1'b0));
        add_row(frame_row(1'b0, 1'b0));
        add_row(frame_row(1'b1, 1'b0));
        add_row(frame_row(1'b0, 1'b1));
        // full-scale registers
        add_row(reg_row(vss_pkg::CFG_MERGE_GAP, 1023));
        add_row(reg_row(vss_pkg::CFG_MIN_SPEECH, 4095));
        add_row(reg_row(vss_pkg::CFG_SHIFT_MS, 127));
        add_row(reg_row(vss_pkg::CFG_FLEN_MS, 255));
        add_row(frame_row(1'b1, 1'b0));
        add_row(frame_row(1'b0, 1'b1));

        foreach (steps[i]) begin
            row = steps[i];
            if (row.kind == ROW_REG) begin
                write_reg(row.reg_idx, row.value);
            end else begin
                send_frame(row.speech, row.eos, row.n_typed >= 0);
                for (int k = 0; k < row.n_typed; k++) queue_word(row.typed[k]);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            for (int i = 0; i < 4; i++)
                write_reg(vss_pkg::t_cfg_idx'(i), phase_cfg[p][i]);
            if (p == N_PHASES - 1) calm = 1'b1;
            if (p == 1) long_hold_req = 1'b1;
            budget      = frames_sent + phase_budget[p];
            paused      = 1'b0;
            do begin
                if ($urandom_range(0, 4) == 0) begin
                    // noise, with the odd early end of stream
                    len = $urandom_range(5, 40);
                    for (int k = 0; k < len; k++)
                        send_frame(1'($urandom_range(0, 1)),
                                   k == len - 1 || $urandom_range(0, 15) == 0, 1'b0);
                end else begin
                    repeat ($urandom_range(0, 3)) send_frame(1'b0, 1'b0, 1'b0);
                    nruns  = (cfg_min > 1000) ? 2 : $urandom_range(1, 4);
                    ending = $urandom_range(0, 2);
                    for (int r = 0; r < nruns; r++) begin
                        len = near_len(cfg_min);
                        for (int k = 0; k < len; k++)
                            send_frame(1'b1, r == nruns - 1 && k == len - 1 && ending == 0,
                                       1'b0);
                        if (r != nruns - 1)
                            repeat (near_len(cfg_merge)) send_frame(1'b0, 1'b0, 1'b0);
                    end
                    if (ending != 0) begin
                        repeat ($urandom_range(0, 2)) send_frame(1'b0, 1'b0, 1'b0);
                        send_frame(ending == 2, 1'b1, 1'b0);
                    end
                end
                if (p == 0 && !paused && frames_sent + phase_budget[p] / 2 >= budget) begin
                    // sender waits until every interval word is out
                    paused = 1'b1;
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    while (interval_q.size() != 0) @(posedge i_clk);
                end
            end while (frames_sent < budget);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (interval_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("vad_segment_smoother_tb: PASS");
        end else begin
            $display("vad_segment_smoother_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/vss_pkg.sv
rtl/vss_front.sv
rtl/vss_queue.sv
rtl/vss_back.sv
rtl/vad_segment_smoother.sv
verif/vad_segment_smoother_tb.sv
